// ===== rtl/core/ptx_pkg.sv =====
package ptx_pkg;

  localparam int COORD_W   = 32;
  localparam int PIXEL_W   = 16;
  localparam int ROT_W     = 32;
  localparam int FRAC_W    = 16;
  localparam int ROT_FRAC  = 30;
  localparam int HALF_W    = 32;
  localparam int CFG_W     = 2 * HALF_W;
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int CFG_IDX_W = 8;

  localparam int VEC_W   = COORD_W + 1;
  localparam int PROD_W  = ROT_W + VEC_W;
  localparam int SUM_W   = PROD_W + 1;
  localparam int DOT_W   = SUM_W - ROT_FRAC;
  localparam int OFS_W   = HALF_W + 1;
  localparam int NUM_W   = OFS_W + DOT_W + 1;
  localparam int HALF_Q  = 1 << (FRAC_W - 1);
  localparam int BA_W    = ((PIXEL_W + FRAC_W > HALF_W) ? PIXEL_W + FRAC_W : HALF_W) + 1;
  localparam int DVD_W   = BA_W + COORD_W;
  localparam int DVR_W   = DOT_W;
  localparam int Q_W     = COORD_W;
  localparam int DIV_STAGES = Q_W;

  localparam int IN_DATA_W  = ((4 * COORD_W + 2 * PIXEL_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((3 * COORD_W + 2 * PIXEL_W + 2 + 7) / 8) * 8;

  localparam int REG_ROT_A    = 0;
  localparam int REG_ROT_B    = 1;
  localparam int REG_ROT_C    = 2;
  localparam int REG_ROT_D    = 3;
  localparam int REG_ROT_E_TX = 4;
  localparam int REG_TRANS_YZ = 5;
  localparam int REG_FOCAL    = 6;
  localparam int REG_PRINC    = 7;

  localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
    64'h4000_0000_0000_0000, 64'h0, 64'h4000_0000_0000_0000, 64'h0,
    64'h4000_0000_0000_0000, 64'h0, 64'h0001_0000_0001_0000, 64'h0
  };

  localparam logic CMD_PROJ = 1'b0;
  localparam logic CMD_BACK = 1'b1;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_SAT  = 2'd2
  } status_t;

  typedef logic signed [ROT_W-1:0] coef_t;
  typedef coef_t [8:0] mat_t;
  typedef logic signed [VEC_W-1:0] vec_t;
  typedef vec_t [2:0] vec3_t;
  typedef logic signed [DOT_W-1:0] dot_t;
  typedef dot_t [2:0] dot3_t;

  typedef struct packed {
    logic [DVR_W-1:0] dvr;
    logic [DVR_W-1:0] rem;
    logic [Q_W-1:0]   lq;
    logic             neg;
    logic             ovf;
  } lane_t;

  typedef struct packed {
    logic                      cmd;
    logic                      zero;
    logic                      fx_zero;
    logic                      fy_zero;
    logic signed [COORD_W-1:0] depth;
  } side_t;

  typedef struct packed {
    lane_t lu;
    lane_t lv;
    side_t side;
  } dcell_t;

  typedef struct packed {
    logic en;
    logic valid;
  } stage_ctl_t;

endpackage

// ===== rtl/core/pinhole_camera_transform_unit.sv =====
// Pinhole camera transform. in_tuser selects the request: low projects the world point to a
// pixel, high back-projects pixel and depth to a world point. One request is taken every clock
// unless backpressure on out_tready stalls the whole pipeline. Each request passes four stages
// of rotation, camera and numerator arithmetic, 32 divider cells producing one quotient bit
// each, then three stages of saturation and inverse rotation. The user must write the camera
// registers through the cfg_ port only while no request is in flight; the block does not enforce it.
module pinhole_camera_transform_unit import ptx_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // world_x, world_y, world_z, pixel_u, pixel_v, depth
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // command
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_u, out_v, out_x, out_y, out_z, status, zero pad
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_W-1:0]      cfg_data
);

  typedef struct packed {
    logic               sat;
    logic [PIXEL_W-1:0] val;
  } pres_t;

  typedef struct packed {
    logic               sat;
    logic [COORD_W-1:0] val;
  } cres_t;

  function automatic pres_t pix_res(lane_t l);
    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] v;
    pres_t          r;
    lim = Q_W'(1) << (PIXEL_W - 1);
    if (!l.neg) lim = lim - Q_W'(1);
    r.sat = l.ovf || (l.lq > lim);
    v = r.sat ? lim : l.lq;
    v = l.neg ? Q_W'(-v) : v;
    r.val = v[PIXEL_W-1:0];
    return r;
  endfunction

  function automatic cres_t crd_res(lane_t l);
    logic [Q_W-1:0] lim;
    logic [Q_W-1:0] v;
    cres_t          r;
    lim = Q_W'(1) << (COORD_W - 1);
    if (!l.neg) lim = lim - Q_W'(1);
    r.sat = l.ovf || (l.lq > lim);
    v = r.sat ? lim : l.lq;
    v = l.neg ? Q_W'(-v) : v;
    r.val = v[COORD_W-1:0];
    return r;
  endfunction

  function automatic cres_t clamp(dot_t x);
    cres_t r;
    r.sat = !(&x[DOT_W-1:COORD_W-1] || ~|x[DOT_W-1:COORD_W-1]);
    if (r.sat) begin
      r.val = x[DOT_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r.val = x[COORD_W-1:0];
    end
    return r;
  endfunction

  function automatic lane_t mk_lane(logic [DVD_W-1:0] dvd, logic [DVR_W-1:0] dvr, logic neg);
    lane_t l;
    l.dvr = dvr;
    l.rem = DVR_W'(dvd[DVD_W-1:Q_W]);
    l.lq  = dvd[Q_W-1:0];
    l.neg = neg;
    l.ovf = (DVR_W'(dvd[DVD_W-1:Q_W]) >= dvr);
    return l;
  endfunction

  // configuration
  logic [CFG_W-1:0] cfg_r [NUM_REGS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_REGS; k++) cfg_r[k] <= CFG_RESET[k];
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      cfg_r[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;

  coef_t r00, r01, r02, r10, r11, r12, r20, r21, r22;
  logic signed [HALF_W-1:0] tx, ty, tz, fx, fy, px, py;

  assign r00 = cfg_r[REG_ROT_A][CFG_W-1:HALF_W];
  assign r01 = cfg_r[REG_ROT_A][HALF_W-1:0];
  assign r02 = cfg_r[REG_ROT_B][CFG_W-1:HALF_W];
  assign r10 = cfg_r[REG_ROT_B][HALF_W-1:0];
  assign r11 = cfg_r[REG_ROT_C][CFG_W-1:HALF_W];
  assign r12 = cfg_r[REG_ROT_C][HALF_W-1:0];
  assign r20 = cfg_r[REG_ROT_D][CFG_W-1:HALF_W];
  assign r21 = cfg_r[REG_ROT_D][HALF_W-1:0];
  assign r22 = cfg_r[REG_ROT_E_TX][CFG_W-1:HALF_W];
  assign tx  = cfg_r[REG_ROT_E_TX][HALF_W-1:0];
  assign ty  = cfg_r[REG_TRANS_YZ][CFG_W-1:HALF_W];
  assign tz  = cfg_r[REG_TRANS_YZ][HALF_W-1:0];
  assign fx  = cfg_r[REG_FOCAL][CFG_W-1:HALF_W];
  assign fy  = cfg_r[REG_FOCAL][HALF_W-1:0];
  assign px  = cfg_r[REG_PRINC][CFG_W-1:HALF_W];
  assign py  = cfg_r[REG_PRINC][HALF_W-1:0];

  mat_t m_fwd, m_bwd;
  assign m_fwd = {r22, r21, r20, r12, r11, r10, r02, r01, r00};
  assign m_bwd = {r22, r12, r02, r21, r11, r01, r20, r10, r00};

  // handshake
  logic en;
  logic out_tvalid_r;

  assign en        = !out_tvalid_r || out_tready;
  assign in_tready = en;

  // input fields
  logic signed [COORD_W-1:0] in_wx, in_wy, in_wz, in_dep;
  logic signed [PIXEL_W-1:0] in_pu, in_pv;
  logic signed [BA_W-1:0]    bu, bv;

  assign in_wx  = in_tdata[COORD_W-1:0];
  assign in_wy  = in_tdata[2*COORD_W-1:COORD_W];
  assign in_wz  = in_tdata[3*COORD_W-1:2*COORD_W];
  assign in_pu  = in_tdata[3*COORD_W+PIXEL_W-1:3*COORD_W];
  assign in_pv  = in_tdata[3*COORD_W+2*PIXEL_W-1:3*COORD_W+PIXEL_W];
  assign in_dep = in_tdata[4*COORD_W+2*PIXEL_W-1:3*COORD_W+2*PIXEL_W];

  assign bu = BA_W'($signed({in_pu, {FRAC_W{1'b0}}})) - BA_W'(px);
  assign bv = BA_W'($signed({in_pv, {FRAC_W{1'b0}}})) - BA_W'(py);

  // stage A: forward rotation products, back-projection numerators
  dot3_t dot_fwd;

  ptx_mat3 u_rot_fwd (
    .clk (clk),
    .en  (en),
    .m   (m_fwd),
    .b   ({VEC_W'(in_wz), VEC_W'(in_wy), VEC_W'(in_wx)}),
    .y   (dot_fwd)
  );

  logic                      va_r, a_cmd_r;
  logic signed [COORD_W-1:0] a_dep_r;
  logic signed [DVD_W-1:0]   a_nbu_r, a_nbv_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_cmd_r <= in_tuser;
      a_dep_r <= in_dep;
      a_nbu_r <= bu * in_dep;
      a_nbv_r <= bv * in_dep;
    end
  end

  // stage B: camera point
  logic                      vb_r, b_cmd_r;
  logic signed [COORD_W-1:0] b_dep_r;
  logic signed [DVD_W-1:0]   b_nbu_r, b_nbv_r;
  dot_t                      b_camx_r, b_camy_r, b_camz_r;

  always_ff @(posedge clk) begin
    if (en) begin
      b_cmd_r  <= a_cmd_r;
      b_dep_r  <= a_dep_r;
      b_nbu_r  <= a_nbu_r;
      b_nbv_r  <= a_nbv_r;
      b_camx_r <= dot_fwd[0] + DOT_W'(tx);
      b_camy_r <= dot_fwd[1] + DOT_W'(ty);
      b_camz_r <= dot_fwd[2] + DOT_W'(tz);
    end
  end

  // stage C: pixel numerator products
  logic signed [OFS_W-1:0]   ofs_x, ofs_y;
  logic                      vc_r, c_cmd_r;
  logic signed [COORD_W-1:0] c_dep_r;
  logic signed [DVD_W-1:0]   c_nbu_r, c_nbv_r;
  dot_t                      c_camz_r;
  logic signed [NUM_W-1:0]   c_pu1_r, c_pu2_r, c_pv1_r, c_pv2_r;

  assign ofs_x = OFS_W'(px) + OFS_W'(HALF_Q);
  assign ofs_y = OFS_W'(py) + OFS_W'(HALF_Q);

  always_ff @(posedge clk) begin
    if (en) begin
      c_cmd_r  <= b_cmd_r;
      c_dep_r  <= b_dep_r;
      c_nbu_r  <= b_nbu_r;
      c_nbv_r  <= b_nbv_r;
      c_camz_r <= b_camz_r;
      c_pu1_r  <= fx * b_camx_r;
      c_pu2_r  <= ofs_x * b_camz_r;
      c_pv1_r  <= fy * b_camy_r;
      c_pv2_r  <= ofs_y * b_camz_r;
    end
  end

  // stage D: divider operands
  logic signed [NUM_W-1:0] nu, nv;
  logic [NUM_W-1:0]        nu_mag, nv_mag;
  logic [DVD_W-1:0]        bu_mag, bv_mag;
  logic [DOT_W-1:0]        cz_mag;
  logic [HALF_W-1:0]       fx_mag, fy_mag;
  dcell_t                  d_nxt, d_r;
  logic                    vd_r;

  always_comb begin
    nu     = c_pu1_r + c_pu2_r;
    nv     = c_pv1_r + c_pv2_r;
    nu_mag = nu[NUM_W-1] ? NUM_W'(-nu) : NUM_W'(nu);
    nv_mag = nv[NUM_W-1] ? NUM_W'(-nv) : NUM_W'(nv);
    bu_mag = c_nbu_r[DVD_W-1] ? DVD_W'(-c_nbu_r) : DVD_W'(c_nbu_r);
    bv_mag = c_nbv_r[DVD_W-1] ? DVD_W'(-c_nbv_r) : DVD_W'(c_nbv_r);
    cz_mag = c_camz_r[DOT_W-1] ? DOT_W'(-c_camz_r) : DOT_W'(c_camz_r);
    fx_mag = fx[HALF_W-1] ? HALF_W'(-fx) : HALF_W'(fx);
    fy_mag = fy[HALF_W-1] ? HALF_W'(-fy) : HALF_W'(fy);
    if (c_cmd_r == CMD_PROJ) begin
      d_nxt.lu = mk_lane(DVD_W'(nu_mag[NUM_W-1:FRAC_W]), DVR_W'(cz_mag),
                         nu[NUM_W-1] ^ c_camz_r[DOT_W-1]);
      d_nxt.lv = mk_lane(DVD_W'(nv_mag[NUM_W-1:FRAC_W]), DVR_W'(cz_mag),
                         nv[NUM_W-1] ^ c_camz_r[DOT_W-1]);
    end else begin
      d_nxt.lu = mk_lane(bu_mag, DVR_W'(fx_mag), c_nbu_r[DVD_W-1] ^ fx[HALF_W-1]);
      d_nxt.lv = mk_lane(bv_mag, DVR_W'(fy_mag), c_nbv_r[DVD_W-1] ^ fy[HALF_W-1]);
    end
    d_nxt.side.cmd     = c_cmd_r;
    d_nxt.side.zero    = (c_camz_r == '0);
    d_nxt.side.fx_zero = (fx == '0);
    d_nxt.side.fy_zero = (fy == '0);
    d_nxt.side.depth   = c_dep_r;
  end

  always_ff @(posedge clk) begin
    if (en) d_r <= d_nxt;
  end

  // divider row
  dcell_t ch_d [DIV_STAGES+1];
  logic   ch_v [DIV_STAGES+1];

  assign ch_d[0] = d_r;
  assign ch_v[0] = vd_r;

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_cell
    stage_ctl_t ctl;
    assign ctl = '{en: en, valid: ch_v[i]};
    ptx_div_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl),
      .d_i     (ch_d[i]),
      .valid_o (ch_v[i+1]),
      .d_o     (ch_d[i+1])
    );
  end

  // stage E: quotient saturation, camera offset
  dcell_t             q;
  pres_t              pu_res, pv_res;
  cres_t              cu_res, cv_res;
  logic [COORD_W-1:0] cam_x, cam_y;
  logic               ve_r, e_cmd_r, e_zero_r, e_sat_r;
  logic [PIXEL_W-1:0] e_ou_r, e_ov_r;
  vec3_t              e_d_r;

  assign q      = ch_d[DIV_STAGES];
  assign pu_res = pix_res(q.lu);
  assign pv_res = pix_res(q.lv);
  assign cu_res = crd_res(q.lu);
  assign cv_res = crd_res(q.lv);
  assign cam_x  = q.side.fx_zero ? '0 : cu_res.val;
  assign cam_y  = q.side.fy_zero ? '0 : cv_res.val;

  always_ff @(posedge clk) begin
    if (en) begin
      e_cmd_r  <= q.side.cmd;
      e_zero_r <= q.side.zero;
      e_ou_r   <= q.side.zero ? '0 : pu_res.val;
      e_ov_r   <= q.side.zero ? '0 : pv_res.val;
      if (q.side.cmd == CMD_PROJ) begin
        e_sat_r <= !q.side.zero && (pu_res.sat || pv_res.sat);
      end else begin
        e_sat_r <= q.side.fx_zero || q.side.fy_zero ||
                   cu_res.sat || cv_res.sat;
      end
      e_d_r[0] <= VEC_W'($signed(cam_x)) - VEC_W'(tx);
      e_d_r[1] <= VEC_W'($signed(cam_y)) - VEC_W'(ty);
      e_d_r[2] <= VEC_W'(q.side.depth) - VEC_W'(tz);
    end
  end

  // stage F: inverse rotation products
  dot3_t              dot_bwd;
  logic               vf_r, f_cmd_r, f_zero_r, f_sat_r;
  logic [PIXEL_W-1:0] f_ou_r, f_ov_r;

  ptx_mat3 u_rot_bwd (
    .clk (clk),
    .en  (en),
    .m   (m_bwd),
    .b   (e_d_r),
    .y   (dot_bwd)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      f_cmd_r  <= e_cmd_r;
      f_zero_r <= e_zero_r;
      f_sat_r  <= e_sat_r;
      f_ou_r   <= e_ou_r;
      f_ov_r   <= e_ov_r;
    end
  end

  // stage G: world clamp and result register
  cres_t              wx_res, wy_res, wz_res;
  logic [PIXEL_W-1:0] out_u_r, out_v_r;
  logic [COORD_W-1:0] out_x_r, out_y_r, out_z_r;
  status_t            out_st_r;

  assign wx_res = clamp(dot_bwd[0]);
  assign wy_res = clamp(dot_bwd[1]);
  assign wz_res = clamp(dot_bwd[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r         <= 1'b0;
      vb_r         <= 1'b0;
      vc_r         <= 1'b0;
      vd_r         <= 1'b0;
      ve_r         <= 1'b0;
      vf_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      va_r         <= in_tvalid;
      vb_r         <= va_r;
      vc_r         <= vb_r;
      vd_r         <= vc_r;
      ve_r         <= ch_v[DIV_STAGES];
      vf_r         <= ve_r;
      out_tvalid_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f_cmd_r == CMD_PROJ) begin
        out_u_r <= f_ou_r;
        out_v_r <= f_ov_r;
        out_x_r <= '0;
        out_y_r <= '0;
        out_z_r <= '0;
        if (f_zero_r) begin
          out_st_r <= ST_ZERO;
        end else if (f_sat_r) begin
          out_st_r <= ST_SAT;
        end else begin
          out_st_r <= ST_OK;
        end
      end else begin
        out_u_r  <= '0;
        out_v_r  <= '0;
        out_x_r  <= wx_res.val;
        out_y_r  <= wy_res.val;
        out_z_r  <= wz_res.val;
        out_st_r <= (f_sat_r || wx_res.sat || wy_res.sat || wz_res.sat) ? ST_SAT : ST_OK;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_DATA_W'({out_st_r, out_z_r, out_y_r, out_x_r, out_v_r, out_u_r});

`ifndef SYNTHESIS
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid_r && (out_st_r == ST_ZERO) |->
      (out_u_r == '0) && (out_v_r == '0) && (out_x_r == '0) && (out_y_r == '0) &&
      (out_z_r == '0))
    else $error("zero-depth result carries nonzero fields");

  a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
      !en |=> $stable(vf_r) && $stable(ve_r) && $stable(vd_r) && $stable(va_r))
    else $error("pipeline moved while stalled");
`endif

endmodule

// ===== rtl/core/ptx_div_cell.sv =====
module ptx_div_cell import ptx_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  stage_ctl_t ctl_i,
  input  dcell_t     d_i,
  output logic       valid_o,
  output dcell_t     d_o
);

  logic   valid_r;
  dcell_t d_r;

  function automatic lane_t step(lane_t l);
    logic [DVR_W:0] rem2;
    logic [DVR_W:0] diff;
    lane_t          r;
    rem2 = {l.rem, l.lq[Q_W-1]};
    diff = rem2 - {1'b0, l.dvr};
    r = l;
    if (rem2 >= {1'b0, l.dvr}) begin
      r.rem = diff[DVR_W-1:0];
      r.lq  = {l.lq[Q_W-2:0], 1'b1};
    end else begin
      r.rem = rem2[DVR_W-1:0];
      r.lq  = {l.lq[Q_W-2:0], 1'b0};
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ctl_i.en) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.en) begin
      d_r.lu   <= step(d_i.lu);
      d_r.lv   <= step(d_i.lv);
      d_r.side <= d_i.side;
    end
  end

  assign valid_o = valid_r;
  assign d_o     = d_r;

endmodule

// ===== rtl/core/ptx_mat3.sv =====
module ptx_mat3 import ptx_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  mat_t  m,
  input  vec3_t b,
  output dot3_t y
);

  logic signed [PROD_W-1:0] p_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          p_r[3*r+c] <= m[3*r+c] * b[c];
        end
      end
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] s;
    for (int r = 0; r < 3; r++) begin
      s = SUM_W'(p_r[3*r]) + SUM_W'(p_r[3*r+1]) + SUM_W'(p_r[3*r+2]);
      y[r] = s[SUM_W-1:ROT_FRAC];
    end
  end

endmodule
